FILE: hdl/nsva_pkg.sv
// Shared types and constants of the note stack voice allocator.
`timescale 1ns / 1ps
package nsva_pkg;

   // Operation codes of a request
   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_TUNE     = 2'd2,
      OP_REFRESH  = 2'd3
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_POLY_MODE   = 2'd0,
      CSR_STACK_LIMIT = 2'd1,
      CSR_MOTOR_COUNT = 2'd2,
      CSR_DRONE_SPEED = 2'd3
   } csr_index_type;

   localparam int RESULT_LIMIT = 8;
   localparam int ENTRY_W      = 11;
   localparam int NOTE_W       = 7;
   localparam int CHAN_W       = 4;
   localparam int SPEED_W      = 16;
   localparam int MOTOR_W      = 3;

   typedef logic [ENTRY_W-1:0] entry_type;
   typedef logic [SPEED_W-1:0] speed_type;

endpackage

FILE: hdl/nsva_stack_mem.sv
// Held-note stack memory: one write port, one registered read port.
`timescale 1ns / 1ps
module nsva_stack_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  nsva_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output nsva_pkg::entry_type rd_data
);
   import nsva_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/nsva_table_mem.sv
// Note-to-speed table with per-entry valid bits; unwritten entries read as zero.
`timescale 1ns / 1ps
module nsva_table_mem #(
   parameter int NOTES = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [nsva_pkg::NOTE_W-1:0] wr_note,
   input  nsva_pkg::speed_type        wr_data,
   input  logic [nsva_pkg::NOTE_W-1:0] rd_note,
   output nsva_pkg::speed_type        rd_data
);
   import nsva_pkg::*;

   localparam int NW = $clog2(NOTES);

   speed_type        mem [NOTES];
   logic [NOTES-1:0] vld_ff;
   speed_type        rd_data_ff;
   logic             rd_ok_ff;
   logic             wr_hit;
   logic             rd_hit;
   logic [NW-1:0]    wr_idx;
   logic [NW-1:0]    rd_idx;

   assign wr_hit = (int'(wr_note) < NOTES);
   assign rd_hit = (int'(rd_note) < NOTES);
   assign wr_idx = wr_note[NW-1:0];
   assign rd_idx = rd_note[NW-1:0];

   // Table storage
   always_ff @(posedge clock) begin
      if (wr_en && wr_hit) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   // Valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en && wr_hit) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         rd_ok_ff <= rd_hit && vld_ff[rd_idx];
      end
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : '0;
endmodule

FILE: hdl/note_stack_voice_allocator_unit.sv
// Sequence: a tune request writes the table from idle; note on/off scans the stack entry by entry,
// closes gaps, drops oldest entries and pushes, then gathers top entries, poly match/serve and one result per motor.
// Flow: one request at a time; a new request is taken only in idle, after the last result of the
// previous one has been issued; results wait on rsp_ready one motor at a time.
// Reset (synchronous): stack empty, motors at zero, table reads zero, registers at defaults.
`timescale 1ns / 1ps
module note_stack_voice_allocator_unit #(
   parameter int STACK_DEPTH = 16,
   parameter int MOTORS      = 8,
   parameter int NOTES       = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_note,
   input  logic [3:0]  req_channel,
   input  logic signed [15:0] req_tune_speed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_motor,
   output logic signed [15:0] rsp_speed,
   output logic        rsp_note_valid,
   output logic [6:0]  rsp_played_note,
   output logic [3:0]  rsp_played_channel,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import nsva_pkg::*;

   localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int MU  = (MOTORS < RESULT_LIMIT) ? MOTORS : RESULT_LIMIT;
   localparam int MCW = $clog2(MU + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CK, S_SH_RD, S_SH_WR, S_DROP, S_PUSH, S_APPLY,
      S_G_RD, S_G_TB, S_G_ST, S_P_MATCH, S_P_SERVE, S_FINAL, S_EMIT
   } state_type;

   state_type state_ff;
   op_type    op_ff;
   entry_type ent_ff;
   logic [CW-1:0]  cnt_ff, idx_ff, k_ff;
   logic           drop_ff;
   logic [MCW-1:0] j_ff, seen_ff, m_ff;
   entry_type g_ent_ff [MU];
   speed_type g_spd_ff [MU];
   speed_type tgt_spd_ff [MU];
   entry_type tgt_ent_ff [MU];
   speed_type mspd_ff [MU];
   logic           tgt_nv_ff;
   logic [MU-1:0]  wait_ff, busy_ff, asg_ff, do_ff;

   logic       cfg_poly_ff;
   logic [4:0] cfg_limit_ff;
   logic [3:0] cfg_count_ff;
   speed_type  cfg_drone_ff;

   logic       rsp_valid_ff, rsp_nv_ff, rsp_last_ff;
   logic [2:0] rsp_motor_ff;
   speed_type  rsp_speed_ff;
   entry_type  rsp_ent_ff;

   // Memory ports
   logic           stk_we;
   logic [AW-1:0]  stk_waddr, stk_raddr;
   entry_type      stk_wdata, stk_rdata;
   logic           tbl_we;
   logic [NOTE_W-1:0] tbl_rnote;
   speed_type      tbl_rdata;

   // Derived values
   logic [CW-1:0]  eff_lim_in;
   logic [MCW-1:0] eff_nm_in;
   logic [MU-1:0]  nmask_in, match_in, mlow_in, free_in, flow_in;
   logic [CW:0]    sh_src_in;
   logic [CW-1:0]  g_addr_in;
   entry_type      sel_ent_in;
   speed_type      sel_spd_in;
   logic           sel_wait_in, cur_do_in, more_do_in, slot_free_in;
   speed_type      cur_spd_in;
   entry_type      cur_ent_in;
   logic           emit_in;

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign slot_free_in = !rsp_valid_ff || rsp_ready;
   assign emit_in      = (state_ff == S_EMIT) && (int'(m_ff) != MU) && cur_do_in
                         && slot_free_in;

   // Effective stack limit and motor count
   always_comb begin
      if (cfg_limit_ff == 5'd0 || int'(cfg_limit_ff) > STACK_DEPTH) begin
         eff_lim_in = CW'(STACK_DEPTH);
      end else begin
         eff_lim_in = CW'(cfg_limit_ff);
      end
      if (cfg_count_ff == 4'd0) begin
         eff_nm_in = MCW'(1);
      end else if (int'(cfg_count_ff) > MU) begin
         eff_nm_in = MCW'(MU);
      end else begin
         eff_nm_in = MCW'(cfg_count_ff);
      end
   end

   // Per-motor selections and masks
   always_comb begin
      sel_ent_in  = '0;
      sel_spd_in  = '0;
      sel_wait_in = 1'b0;
      cur_do_in   = 1'b0;
      more_do_in  = 1'b0;
      cur_spd_in  = '0;
      cur_ent_in  = '0;
      for (int i = 0; i < MU; i++) begin
         nmask_in[i] = (i < int'(eff_nm_in));
         match_in[i] = nmask_in[i] && (mspd_ff[i] == sel_spd_in);
         if (j_ff == MCW'(i)) begin
            sel_ent_in  = g_ent_ff[i];
            sel_spd_in  = g_spd_ff[i];
            sel_wait_in = wait_ff[i];
         end
         if (m_ff == MCW'(i)) begin
            cur_do_in  = do_ff[i];
            cur_spd_in = tgt_spd_ff[i];
            cur_ent_in = tgt_ent_ff[i];
         end
         if (i > int'(m_ff) && do_ff[i]) begin
            more_do_in = 1'b1;
         end
      end
      for (int i = 0; i < MU; i++) begin
         match_in[i] = nmask_in[i] && (mspd_ff[i] == sel_spd_in);
      end
      free_in   = ~busy_ff & nmask_in;
      mlow_in   = match_in & (~match_in + MU'(1));
      flow_in   = free_in & (~free_in + MU'(1));
      sh_src_in = {1'b0, idx_ff} + {1'b0, k_ff};
      g_addr_in = cnt_ff - CW'(1) - CW'(j_ff);
   end

   // Memory port control
   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = AW'(idx_ff);
      stk_wdata = stk_rdata;
      stk_raddr = AW'(idx_ff);
      tbl_rnote = stk_rdata[ENTRY_W-1:CHAN_W];
      unique case (state_ff)
         S_SH_RD: stk_raddr = AW'(sh_src_in);
         S_SH_WR: stk_we = 1'b1;
         S_PUSH: begin
            stk_we    = (int'(cnt_ff) < STACK_DEPTH);
            stk_waddr = AW'(cnt_ff);
            stk_wdata = ent_ff;
         end
         S_G_RD: stk_raddr = AW'(g_addr_in);
         default: ;
      endcase
   end
   assign tbl_we = (state_ff == S_IDLE) && req_valid && (op_type'(req_op) == OP_TUNE);

   nsva_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   nsva_table_mem #(.NOTES(NOTES)) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_we),
      .wr_note (req_note),
      .wr_data (req_tune_speed),
      .rd_note (tbl_rnote),
      .rd_data (tbl_rdata)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_poly_ff  <= 1'b0;
         cfg_limit_ff <= 5'd16;
         cfg_count_ff <= 4'd8;
         cfg_drone_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_POLY_MODE:   cfg_poly_ff  <= csr_data[0];
            CSR_STACK_LIMIT: cfg_limit_ff <= csr_data[4:0];
            CSR_MOTOR_COUNT: cfg_count_ff <= csr_data[3:0];
            CSR_DRONE_SPEED: cfg_drone_ff <= csr_data;
         endcase
      end
   end

   // Result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_in) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         for (int i = 0; i < MU; i++) begin
            mspd_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff   <= op_type'(req_op);
                  ent_ff  <= {req_note, req_channel};
                  idx_ff  <= '0;
                  drop_ff <= 1'b0;
                  unique case (op_type'(req_op))
                     OP_NOTE_ON, OP_NOTE_OFF: state_ff <= S_SCAN_RD;
                     OP_TUNE:                 state_ff <= S_IDLE;
                     OP_REFRESH:              state_ff <= S_APPLY;
                  endcase
               end
            end
            // Search for a matching held note
            S_SCAN_RD: begin
               if (idx_ff == cnt_ff) begin
                  state_ff <= (op_ff == OP_NOTE_ON) ? S_DROP : S_APPLY;
               end else begin
                  state_ff <= S_SCAN_CK;
               end
            end
            S_SCAN_CK: begin
               if (stk_rdata == ent_ff) begin
                  k_ff     <= CW'(1);
                  state_ff <= S_SH_RD;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            // Close a gap of k entries starting at idx
            S_SH_RD: begin
               if (sh_src_in < {1'b0, cnt_ff}) begin
                  state_ff <= S_SH_WR;
               end else begin
                  cnt_ff <= cnt_ff - k_ff;
                  if (drop_ff) begin
                     state_ff <= S_PUSH;
                  end else begin
                     state_ff <= (op_ff == OP_NOTE_ON) ? S_DROP : S_APPLY;
                  end
               end
            end
            S_SH_WR: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_SH_RD;
            end
            // Drop oldest entries until there is room
            S_DROP: begin
               if (cnt_ff != '0 && cnt_ff >= eff_lim_in) begin
                  k_ff     <= cnt_ff - eff_lim_in + CW'(1);
                  idx_ff   <= '0;
                  drop_ff  <= 1'b1;
                  state_ff <= S_SH_RD;
               end else begin
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (int'(cnt_ff) < STACK_DEPTH) begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
               state_ff <= S_APPLY;
            end
            // Start driving the motors
            S_APPLY: begin
               j_ff    <= '0;
               busy_ff <= '0;
               wait_ff <= '0;
               if (cnt_ff == '0) begin
                  for (int i = 0; i < MU; i++) begin
                     tgt_spd_ff[i] <= cfg_drone_ff;
                     tgt_ent_ff[i] <= '0;
                  end
                  tgt_nv_ff <= 1'b0;
                  asg_ff    <= nmask_in;
                  state_ff  <= S_FINAL;
               end else begin
                  asg_ff <= '0;
                  if (!cfg_poly_ff) begin
                     seen_ff <= MCW'(1);
                  end else if (int'(cnt_ff) < int'(eff_nm_in)) begin
                     seen_ff <= MCW'(cnt_ff);
                  end else begin
                     seen_ff <= eff_nm_in;
                  end
                  state_ff <= S_G_RD;
               end
            end
            // Gather top entries and their table speeds
            S_G_RD: state_ff <= S_G_TB;
            S_G_TB: begin
               for (int i = 0; i < MU; i++) begin
                  if (j_ff == MCW'(i)) begin
                     g_ent_ff[i] <= stk_rdata;
                  end
               end
               state_ff <= S_G_ST;
            end
            S_G_ST: begin
               for (int i = 0; i < MU; i++) begin
                  if (j_ff == MCW'(i)) begin
                     g_spd_ff[i] <= tbl_rdata;
                  end
               end
               if (j_ff + MCW'(1) == seen_ff) begin
                  if (cfg_poly_ff) begin
                     j_ff     <= '0;
                     state_ff <= S_P_MATCH;
                  end else begin
                     for (int i = 0; i < MU; i++) begin
                        tgt_spd_ff[i] <= tbl_rdata;
                        tgt_ent_ff[i] <= g_ent_ff[0];
                     end
                     tgt_nv_ff <= 1'b1;
                     asg_ff    <= nmask_in;
                     state_ff  <= S_FINAL;
                  end
               end else begin
                  j_ff     <= j_ff + MCW'(1);
                  state_ff <= S_G_RD;
               end
            end
            // Keep motors already at a note's speed, queue the rest
            S_P_MATCH: begin
               if (match_in != '0) begin
                  busy_ff <= busy_ff | mlow_in;
               end else begin
                  for (int i = 0; i < MU; i++) begin
                     if (j_ff == MCW'(i)) begin
                        wait_ff[i] <= 1'b1;
                     end
                  end
               end
               if (j_ff + MCW'(1) == seen_ff) begin
                  state_ff <= S_P_SERVE;
               end else begin
                  j_ff <= j_ff + MCW'(1);
               end
            end
            // Serve queued notes, oldest queued first, to the lowest free motor
            S_P_SERVE: begin
               tgt_nv_ff <= 1'b1;
               if (sel_wait_in && free_in != '0) begin
                  busy_ff <= busy_ff | flow_in;
                  asg_ff  <= asg_ff | flow_in;
                  for (int i = 0; i < MU; i++) begin
                     if (flow_in[i]) begin
                        tgt_spd_ff[i] <= sel_spd_in;
                        tgt_ent_ff[i] <= sel_ent_in;
                     end
                  end
               end
               if (j_ff == '0) begin
                  state_ff <= S_FINAL;
               end else begin
                  j_ff <= j_ff - MCW'(1);
               end
            end
            // Commit changed speeds
            S_FINAL: begin
               for (int i = 0; i < MU; i++) begin
                  do_ff[i] <= asg_ff[i] && (mspd_ff[i] != tgt_spd_ff[i]);
                  if (asg_ff[i]) begin
                     mspd_ff[i] <= tgt_spd_ff[i];
                  end
               end
               m_ff     <= '0;
               state_ff <= S_EMIT;
            end
            // Emit one result per changed motor
            S_EMIT: begin
               if (int'(m_ff) == MU) begin
                  state_ff <= S_IDLE;
               end else if (!cur_do_in) begin
                  m_ff <= m_ff + MCW'(1);
               end else if (slot_free_in) begin
                  rsp_motor_ff <= MOTOR_W'(m_ff);
                  rsp_speed_ff <= cur_spd_in;
                  rsp_nv_ff    <= tgt_nv_ff;
                  rsp_ent_ff   <= cur_ent_in;
                  rsp_last_ff  <= !more_do_in;
                  m_ff         <= m_ff + MCW'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor          = rsp_motor_ff;
   assign rsp_speed          = rsp_speed_ff;
   assign rsp_note_valid     = rsp_nv_ff;
   assign rsp_played_note    = rsp_ent_ff[ENTRY_W-1:CHAN_W];
   assign rsp_played_channel = rsp_ent_ff[CHAN_W-1:0];
   assign rsp_last           = rsp_last_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= STACK_DEPTH)
      else $error("stack count beyond depth");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == S_IDLE) && !rsp_valid_ff)
      else $error("not idle after reset");
   a_assign_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL) |-> ((asg_ff & ~nmask_in) == '0))
      else $error("motor beyond count assigned");
`endif
endmodule

FILE: test/tb_top.sv
// Self-checking testbench of the note stack voice allocator, with a predictor of its own.
`timescale 1ns / 1ps
module tb_top;
   import nsva_pkg::*;

   localparam int STACK_DEPTH = 16;
   localparam int MOTORS      = 8;
   localparam int NOTES       = 128;
   localparam int DRAIN_WAIT  = 300;
   localparam int CYCLE_LIMIT = 800000;

   typedef struct packed {
      logic [2:0]  motor;
      speed_type   speed;
      logic        note_valid;
      logic [6:0]  played_note;
      logic [3:0]  played_channel;
      logic        last;
   } motor_update_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_op;
   logic [6:0] req_note;
   logic [3:0] req_channel;
   logic signed [15:0] req_tune_speed;
   logic rsp_valid, rsp_ready;
   logic [2:0] rsp_motor;
   logic signed [15:0] rsp_speed;
   logic rsp_note_valid;
   logic [6:0] rsp_played_note;
   logic [3:0] rsp_played_channel;
   logic rsp_last;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_data;

   // Mirror of the block's registers and state
   logic       mdl_poly;
   logic [4:0] mdl_stack_limit;
   logic [3:0] mdl_motor_count;
   speed_type  mdl_drone;
   entry_type  held[STACK_DEPTH];
   int         held_cnt;
   speed_type  note_speed[NOTES];
   speed_type  motor_spd[MOTORS];

   motor_update_type pending_updates[$];
   int  errors = 0;
   int  cycles = 0;
   bit  no_idle = 1'b0;
   int  ready_hold = 0;

   note_stack_voice_allocator_unit DUT (.*);

   always #2 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result-side stall pattern, changes at the falling edge
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready  <= ~rsp_ready;
         ready_hold <= rsp_ready ? pick_gap() : $urandom_range(0, 6);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      motor_update_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_motor, rsp_speed, rsp_note_valid, rsp_played_note,
                 rsp_played_channel, rsp_last};
         if (pending_updates.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_updates.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   function automatic int active_motors();
      int m;
      m = mdl_motor_count;
      if (m < 1) m = 1;
      if (m > MOTORS) m = MOTORS;
      if (m > RESULT_LIMIT) m = RESULT_LIMIT;
      return m;
   endfunction

   function automatic int hold_limit();
      if (mdl_stack_limit < 1 || mdl_stack_limit > STACK_DEPTH) return STACK_DEPTH;
      return mdl_stack_limit;
   endfunction

   function automatic void remove_held(int pos);
      for (int i = pos; i + 1 < held_cnt; i++) held[i] = held[i + 1];
      held_cnt--;
   endfunction

   function automatic void remove_note(entry_type e);
      for (int i = 0; i < held_cnt; i++) begin
         if (held[i] == e) begin
            remove_held(i);
            return;
         end
      end
   endfunction

   // Set one motor and queue an update if the speed moves
   function automatic void set_motor(int m, speed_type s, logic v, entry_type e);
      if (motor_spd[m] == s) return;
      motor_spd[m] = s;
      pending_updates.push_back('{m[2:0], s, v, v ? e[10:4] : 7'd0,
                                  v ? e[3:0] : 4'd0, 1'b0});
   endfunction

   // Re-drive the motors from the held notes
   function automatic void drive_motors();
      int nm, nwait, seen, queued_prior;
      bit busy[RESULT_LIMIT];
      bit assigned[RESULT_LIMIT];
      entry_type waiting[RESULT_LIMIT];
      entry_type new_ent[RESULT_LIMIT];
      entry_type e;
      bit found;
      nm = active_motors();
      queued_prior = pending_updates.size();
      if (held_cnt == 0) begin
         for (int m = 0; m < nm; m++) set_motor(m, mdl_drone, 1'b0, '0);
      end else if (!mdl_poly) begin
         e = held[held_cnt - 1];
         for (int m = 0; m < nm; m++) set_motor(m, note_speed[e[10:4]], 1'b1, e);
      end else begin
         busy = '{default: 0};
         assigned = '{default: 0};
         nwait = 0;
         seen = 0;
         for (int i = held_cnt; i > 0 && seen < nm; i--, seen++) begin
            e = held[i - 1];
            found = 0;
            for (int m = 0; m < nm && !found; m++) begin
               if (motor_spd[m] == note_speed[e[10:4]]) begin
                  busy[m] = 1;
                  found = 1;
               end
            end
            if (!found && nwait < RESULT_LIMIT) waiting[nwait++] = e;
         end
         for (int w = nwait; w > 0; w--) begin
            found = 0;
            for (int m = 0; m < nm && !found; m++) begin
               if (!busy[m]) begin
                  busy[m] = 1;
                  assigned[m] = 1;
                  new_ent[m] = waiting[w - 1];
                  found = 1;
               end
            end
         end
         for (int m = 0; m < nm; m++)
            if (assigned[m]) set_motor(m, note_speed[new_ent[m][10:4]], 1'b1, new_ent[m]);
      end
      if (pending_updates.size() > queued_prior)
         pending_updates[pending_updates.size() - 1].last = 1'b1;
   endfunction

   function automatic void predict_request(op_type op, logic [6:0] n, logic [3:0] c,
                                           speed_type s);
      entry_type e;
      e = {n, c};
      case (op)
         OP_NOTE_ON: begin
            remove_note(e);
            while (held_cnt > 0 && held_cnt >= hold_limit()) remove_held(0);
            if (held_cnt < STACK_DEPTH) held[held_cnt++] = e;
            drive_motors();
         end
         OP_NOTE_OFF: begin
            remove_note(e);
            drive_motors();
         end
         OP_TUNE: begin
            if (n < NOTES) note_speed[n] = s;
         end
         default: drive_motors();
      endcase
   endfunction

   // Send one request; valid stays up if the next one follows at once
   task automatic send_request(op_type op, logic [6:0] n, logic [3:0] c, speed_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_note = n;
      req_channel = c;
      req_tune_speed = s;
      do @(posedge clock); while (!req_ready);
      predict_request(op, n, c, s);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      @(negedge clock);
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_POLY_MODE:   mdl_poly = value[0];
         CSR_STACK_LIMIT: mdl_stack_limit = value[4:0];
         CSR_MOTOR_COUNT: mdl_motor_count = value[3:0];
         default:         mdl_drone = value;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(logic poly, logic [4:0] lim, logic [3:0] mc, speed_type drone);
      wait_drained();
      write_csr(CSR_POLY_MODE, {15'd0, poly});
      write_csr(CSR_STACK_LIMIT, {11'd0, lim});
      write_csr(CSR_MOTOR_COUNT, {12'd0, mc});
      write_csr(CSR_DRONE_SPEED, drone);
   endtask

   // Mostly a small pool of notes so that note-offs and repeats hit held notes
   task automatic random_request();
      int r;
      logic [6:0] n;
      logic [3:0] c;
      speed_type s;
      r = $urandom_range(0, 99);
      n = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(60, 69));
      c = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 1));
      s = ($urandom_range(0, 2) == 0) ? speed_type'($urandom) : speed_type'($urandom_range(1, 5) * 100);
      if (r < 42)      send_request(OP_NOTE_ON, n, c, s);
      else if (r < 72) send_request(OP_NOTE_OFF, n, c, s);
      else if (r < 87) send_request(OP_TUNE, n, c, s);
      else             send_request(OP_REFRESH, n, c, s);
   endtask

   // Field extremes, each operation, empty-stack and unheld removals, unchanged speeds
   task automatic test_directed();
      send_request(OP_NOTE_OFF, 7'd5, 4'd3, 16'h0000);
      send_request(OP_REFRESH, 7'd0, 4'd0, 16'h0000);
      send_request(OP_TUNE, 7'd0, 4'd0, 16'h8000);
      send_request(OP_TUNE, 7'd127, 4'd15, 16'h7FFF);
      send_request(OP_TUNE, 7'd64, 4'd0, 16'hFFFF);
      send_request(OP_TUNE, 7'd42, 4'd9, 16'h5555);
      send_request(OP_NOTE_ON, 7'd127, 4'd15, 16'h0000);
      send_request(OP_NOTE_ON, 7'd0, 4'd0, 16'hFFFF);
      send_request(OP_NOTE_ON, 7'd127, 4'd15, 16'h0000);
      send_request(OP_NOTE_ON, 7'd64, 4'd10, 16'h0000);
      send_request(OP_NOTE_OFF, 7'd64, 4'd11, 16'h0000);
      send_request(OP_REFRESH, 7'd127, 4'd15, 16'h7FFF);
      send_request(OP_NOTE_OFF, 7'd64, 4'd10, 16'h0000);
      send_request(OP_NOTE_OFF, 7'd127, 4'd15, 16'h0000);
      send_request(OP_NOTE_OFF, 7'd0, 4'd0, 16'h0000);
      send_request(OP_NOTE_ON, 7'd42, 4'd5, 16'h0000);
      send_request(OP_NOTE_OFF, 7'd42, 4'd5, 16'h0000);
   endtask

   // Poly allocation with distinct and shared speeds, then a lowered stack limit
   task automatic test_poly();
      set_config(1'b1, 5'd16, 4'd8, 16'h8000);
      for (int i = 0; i < 10; i++)
         send_request(OP_TUNE, 7'(60 + i), 4'd0, speed_type'((i % 6 + 1) * 100));
      for (int i = 0; i < 30; i++) random_request();
      set_config(1'b1, 5'd3, 4'd4, 16'h7FFF);
      for (int i = 0; i < 30; i++) random_request();
   endtask

   // Out-of-range limit and count values, single motor and single entry
   task automatic test_register_extremes();
      set_config(1'b0, 5'd1, 4'd1, 16'h1234);
      for (int i = 0; i < 20; i++) random_request();
      set_config(1'b1, 5'd0, 4'd0, 16'hEDCB);
      for (int i = 0; i < 20; i++) random_request();
      set_config(1'b1, 5'd31, 4'd15, 16'h0000);
      for (int i = 0; i < 30; i++) random_request();
   endtask

   // Back-to-back requests with no stalls, then mono with random stalls
   task automatic test_streaming();
      no_idle = 1'b1;
      for (int i = 0; i < 25; i++) random_request();
      no_idle = 1'b0;
      set_config(1'b0, 5'd16, 4'd8, 16'hFFFF);
      for (int i = 0; i < 30; i++) random_request();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_NOTE_ON;
      req_note = '0;
      req_channel = '0;
      req_tune_speed = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_POLY_MODE;
      csr_data = '0;
      mdl_poly = 1'b0;
      mdl_stack_limit = 5'd16;
      mdl_motor_count = 4'd8;
      mdl_drone = '0;
      held_cnt = 0;
      for (int i = 0; i < NOTES; i++) note_speed[i] = '0;
      for (int i = 0; i < MOTORS; i++) motor_spd[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_poly();
      test_register_extremes();
      test_streaming();
      wait_drained();

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
